// ----- hdl/wfs_pkg.sv -----
package wfs_pkg;

  localparam int HASH_BITS = 64;
  localparam int WLEN_BITS = 7;
  localparam int POS_OUT_BITS = 32;
  localparam int MAX_WINDOW_DEF = 64;
  localparam int POSITION_BITS_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd4;
  localparam logic signed [HASH_BITS-1:0] HASH_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [0:0] {
    ITEM_NEXT  = 1'b0,
    ITEM_START = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic signed [HASH_BITS-1:0] hash;
    item_kind_t                  kind;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

endpackage

// ----- hdl/wfs_if.sv -----
interface wfs_item_if;
  import wfs_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [HASH_BITS-1:0] hash_value;
  logic                        start_of_list;

  modport source (output valid, output hash_value, output start_of_list, input ready);
  modport sink (input valid, input hash_value, input start_of_list, output ready);
endinterface

interface wfs_result_if;
  import wfs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [POS_OUT_BITS-1:0] selected_position;

  modport source (output valid, output selected_position, input ready);
  modport sink (input valid, input selected_position, output ready);
endinterface

// ----- hdl/wfs_ram.sv -----
module wfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/wfs_front.sv -----
module wfs_front (
  input  logic            clk,
  input  logic            rst,
  wfs_item_if.sink        in,
  output wfs_pkg::queue_t q,
  input  logic            q_pop
);
  import wfs_pkg::*;

  item_t      entry [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in.ready = (fill != 2'(QUEUE_DEPTH));
  assign push     = in.valid && in.ready;
  assign pop      = q_pop && (fill != 2'd0);

  assign q.valid = (fill != 2'd0);
  assign q.item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        entry[wr_ptr].hash <= in.hash_value;
        entry[wr_ptr].kind <= in.start_of_list ? ITEM_START : ITEM_NEXT;
        wr_ptr             <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/wfs_back.sv -----
module wfs_back #(
  parameter int MAX_WINDOW    = wfs_pkg::MAX_WINDOW_DEF,
  parameter int POSITION_BITS = wfs_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    eff_window,
  input  wfs_pkg::queue_t                    q,
  output logic                               q_pop,
  wfs_result_if.source                       out
);
  import wfs_pkg::*;

  localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WRAP = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_SCAN = 4'b1000
  } state_t;

  state_t                      state;
  logic [MAX_WINDOW-1:0]       slot_valid;
  logic [SLOT_BITS-1:0]        head;
  logic [SLOT_BITS-1:0]        min_slot;
  logic [POSITION_BITS-1:0]    count;
  logic [POSITION_BITS-1:0]    pos;
  logic signed [HASH_BITS-1:0] hash_cur;
  logic signed [HASH_BITS-1:0] best;
  logic [SLOT_BITS-1:0]        scan_idx;
  logic [SLOT_BITS-1:0]        rd_idx;
  logic                        rd_pend;
  logic                        res_valid;
  logic [POS_OUT_BITS-1:0]     res_pos;

  logic [WIN_BITS-1:0]         head_w;
  logic [WIN_BITS-1:0]         min_w;
  logic [WIN_BITS-1:0]         head_inc;
  logic [SLOT_BITS-1:0]        slot_r;
  logic                        head_wrap;
  logic                        min_wrap;
  logic                        pop_ok;
  logic                        ram_we;
  logic [SLOT_BITS-1:0]        ram_raddr;
  logic [HASH_BITS-1:0]        ram_rdata;
  logic signed [HASH_BITS-1:0] min_val;
  logic signed [HASH_BITS-1:0] cand;
  logic [WIN_BITS-1:0]         lag;
  logic [63:0]                 pos64;
  logic [63:0]                 dist64;
  logic [63:0]                 report64;

  function automatic logic [SLOT_BITS-1:0] slot_dec(input logic [SLOT_BITS-1:0] s,
                                                    input logic [WIN_BITS-1:0]  w);
    slot_dec = (s == '0) ? SLOT_BITS'(w - 1'b1) : s - 1'b1;
  endfunction

  assign head_w    = WIN_BITS'(head);
  assign min_w     = WIN_BITS'(min_slot);
  assign head_inc  = head_w + 1'b1;
  assign slot_r    = (head_inc == eff_window) ? '0 : SLOT_BITS'(head_inc);
  assign head_wrap = (head_w >= eff_window);
  assign min_wrap  = (min_w >= eff_window);

  assign pop_ok = (state == ST_IDLE) && q.valid && (!res_valid || out.ready);
  assign q_pop  = pop_ok;

  assign ram_we    = (state == ST_WRAP) && !head_wrap && !min_wrap;
  assign ram_raddr = (state == ST_SCAN) ? scan_idx : min_slot;

  wfs_ram #(
    .WIDTH (HASH_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (hash_cur),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written slots read as the top value
  assign min_val = slot_valid[min_slot] ? $signed(ram_rdata) : HASH_TOP;
  assign cand    = slot_valid[rd_idx] ? $signed(ram_rdata) : HASH_TOP;

  assign lag      = (head_w >= min_w) ? head_w - min_w : head_w + eff_window - min_w;
  assign pos64    = 64'(pos);
  assign dist64   = 64'(lag);
  assign report64 = (pos64 >= dist64) ? pos64 - dist64 : '0;

  assign out.valid             = res_valid;
  assign out.selected_position = res_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      head       <= '0;
      min_slot   <= '0;
      count      <= '0;
      rd_pend    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && out.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop_ok) begin
            hash_cur <= q.item.hash;
            if (q.item.kind == ITEM_START) begin
              slot_valid <= '0;
              head       <= '0;
              min_slot   <= '0;
              count      <= '0;
              pos        <= '0;
            end else begin
              pos <= count;
            end
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (head_wrap) begin
            head <= SLOT_BITS'(head_w - eff_window);
          end else if (min_wrap) begin
            min_slot <= SLOT_BITS'(min_w - eff_window);
          end else begin
            slot_valid[slot_r] <= 1'b1;
            head               <= slot_r;
            if (min_slot == slot_r) begin
              best     <= hash_cur;
              scan_idx <= slot_dec(slot_r, eff_window);
              rd_pend  <= 1'b0;
              state    <= ST_SCAN;
            end else begin
              state <= ST_CMP;
            end
          end
        end
        ST_CMP: begin
          if (hash_cur < min_val) begin
            min_slot  <= head;
            res_valid <= 1'b1;
            res_pos   <= pos64[POS_OUT_BITS-1:0];
          end
          if (!(&count)) begin
            count <= count + 1'b1;
          end
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (rd_pend && (cand < best)) begin
            best     <= cand;
            min_slot <= rd_idx;
          end
          if (scan_idx != head) begin
            rd_idx   <= scan_idx;
            rd_pend  <= 1'b1;
            scan_idx <= slot_dec(scan_idx, eff_window);
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              res_valid <= 1'b1;
              res_pos   <= report64[POS_OUT_BITS-1:0];
              if (!(&count)) begin
                count <= count + 1'b1;
              end
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/winnowing_fingerprint_select.sv -----
// channel   dir  handshake      payload
// in        in   valid/ready    hash_value[63:0] signed, start_of_list
// out       out  valid/ready    selected_position[31:0]
// cfg       in   cfg_write      cfg_data[6:0] = window_length
//
// An item passes through the idle, wrap and compare states when the minimum stays
// in the window; when it leaves, the ring is rescanned in the scan state, one ring
// read a cycle on the single read port. A window change adds a wrap step for each
// wrap-around of the ring pointers. Reset is synchronous and clears the ring
// valid bits at once; no clearing pass. A 2-item queue lets input accept run
// ahead while the output register holds a result the sink has not taken.
module winnowing_fingerprint_select #(
  parameter int MAX_WINDOW    = wfs_pkg::MAX_WINDOW_DEF,
  parameter int POSITION_BITS = wfs_pkg::POSITION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  wfs_item_if.sink                       in,
  wfs_result_if.source                   out,
  input  logic                           cfg_write,
  input  logic [wfs_pkg::WLEN_BITS-1:0]  cfg_data
);
  import wfs_pkg::*;

  localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);

  logic [WLEN_BITS-1:0] window_length;
  logic [WIN_BITS-1:0]  eff_window;
  queue_t               q;
  logic                 q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
    end else if (cfg_write) begin
      window_length <= cfg_data;
    end
  end

  always_comb begin
    if (window_length == '0) begin
      eff_window = WIN_BITS'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      eff_window = WIN_BITS'(MAX_WINDOW);
    end else begin
      eff_window = WIN_BITS'(window_length);
    end
  end

  wfs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in    (in),
    .q     (q),
    .q_pop (q_pop)
  );

  wfs_back #(
    .MAX_WINDOW    (MAX_WINDOW),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .eff_window (eff_window),
    .q          (q),
    .q_pop      (q_pop),
    .out        (out)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q.valid)
    else $error("queue pop while empty");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!out.valid || out.ready))
    else $error("item started while result still held");

  a_one_result_per_pop: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> !$past(q_pop))
    else $error("item started while result stalled");

endmodule

// ----- tb/tb_winnowing_fingerprint_select.sv -----
module tb_winnowing_fingerprint_select;
  import wfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIN = MAX_WINDOW_DEF;
  localparam longint unsigned COUNT_MAX = (64'd1 << POSITION_BITS_DEF) - 64'd1;
  localparam logic signed [HASH_BITS-1:0] HASH_BOTTOM = {1'b1, {(HASH_BITS-1){1'b0}}};
  localparam int SETTLE_CYCLES = 250;
  localparam int PRESSURE_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int PRINT_LIMIT = 30;

  typedef enum int {
    STYLE_RANDOM,
    STYLE_TIES,
    STYLE_EXTREME,
    STYLE_RAMP
  } hash_style_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [WLEN_BITS-1:0] cfg_data;

  wfs_item_if in_if ();
  wfs_result_if out_if ();

  winnowing_fingerprint_select dut (
    .clk(clk),
    .rst(rst),
    .in(in_if),
    .out(out_if),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // model state of the block
  logic signed [HASH_BITS-1:0] ring_q [MAX_WIN];
  int unsigned head_q;
  int unsigned min_q;
  longint unsigned count_q;
  logic [WLEN_BITS-1:0] wlen_q;
  logic [POS_OUT_BITS-1:0] pending_positions [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  bit hold_request = 1'b0;
  logic signed [HASH_BITS-1:0] ramp_value = '0;

  function automatic int unsigned effective_width(input logic [WLEN_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIN) return MAX_WIN;
    return v;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < MAX_WIN; i++) ring_q[i] = HASH_TOP;
    head_q = 0;
    min_q = 0;
    count_q = 0;
  endfunction

  function automatic void winnow_step(input item_kind_t kind,
                                      input logic signed [HASH_BITS-1:0] hash);
    int unsigned w;
    int unsigned r;
    int unsigned i;
    int unsigned lag;
    longint unsigned pos;
    w = effective_width(wlen_q);
    pos = count_q;
    if (kind == ITEM_START) begin
      clear_ring();
      pos = 0;
    end
    head_q = head_q % w;
    min_q = min_q % w;
    r = (head_q + 1) % w;
    head_q = r;
    ring_q[r] = hash;
    if (min_q == r) begin
      // minimum left the window: scan back from the newest entry
      i = (r + w - 1) % w;
      while (i != r) begin
        if (ring_q[i] < ring_q[min_q]) min_q = i;
        i = (i + w - 1) % w;
      end
      lag = (r + w - min_q) % w;
      pending_positions.push_back((pos >= lag) ? 32'(pos - lag) : 32'd0);
    end else if (ring_q[r] < ring_q[min_q]) begin
      min_q = r;
      pending_positions.push_back(32'(pos));
    end
    if (count_q < COUNT_MAX) count_q++;
  endfunction

  function automatic logic signed [HASH_BITS-1:0] pick_hash(input hash_style_t style);
    logic signed [HASH_BITS-1:0] v;
    case (style)
      STYLE_TIES: v = longint'($urandom_range(0, 6)) - 64'sd3;
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = HASH_TOP;
          1: v = HASH_BOTTOM;
          2: v = -64'sd1;
          3: v = '0;
          default: v = {$urandom, $urandom};
        endcase
      end
      STYLE_RAMP: begin
        ramp_value = ramp_value + longint'($urandom_range(0, 3));
        v = ramp_value;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic item_kind_t stray_kind();
    return ($urandom_range(0, 39) == 0) ? ITEM_START : ITEM_NEXT;
  endfunction

  task automatic flag_mismatch(input string what, input logic [POS_OUT_BITS-1:0] want,
                               input logic [POS_OUT_BITS-1:0] got);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  task automatic send_item(input item_kind_t kind, input logic signed [HASH_BITS-1:0] hash);
    int unsigned gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.hash_value <= hash;
    in_if.start_of_list <= (kind == ITEM_START);
    do @(posedge clk); while (!in_if.ready);
    winnow_step(kind, hash);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WLEN_BITS-1:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    wlen_q = v;
    @(posedge clk);
  endtask

  task automatic test_default_window();
    send_item(ITEM_NEXT, 64'sd10);
    send_item(ITEM_NEXT, 64'sd20);
    send_item(ITEM_NEXT, 64'sd5);
    send_item(ITEM_NEXT, 64'sd5);
    send_item(ITEM_NEXT, 64'sd30);
    send_item(ITEM_NEXT, 64'sd40);
    send_item(ITEM_NEXT, 64'sd50);
    send_item(ITEM_START, 64'sd7);
    send_item(ITEM_NEXT, 64'sd7);
  endtask

  task automatic test_hash_extremes();
    wait_drained();
    write_window(7'd2);
    send_item(ITEM_START, HASH_TOP);
    send_item(ITEM_NEXT, HASH_TOP);
    send_item(ITEM_NEXT, HASH_TOP);
    send_item(ITEM_NEXT, HASH_BOTTOM);
    send_item(ITEM_NEXT, HASH_BOTTOM);
    send_item(ITEM_NEXT, -64'sd1);
    send_item(ITEM_NEXT, 64'sd0);
    send_item(ITEM_NEXT, 64'shAAAA_AAAA_AAAA_AAAA);
    send_item(ITEM_NEXT, 64'sh5555_5555_5555_5555);
    send_item(ITEM_NEXT, 64'sd1);
  endtask

  // window changes with no start in between
  task automatic test_window_change_midstream();
    wait_drained();
    write_window(7'd0);
    send_item(ITEM_NEXT, 64'sd3);
    send_item(ITEM_NEXT, 64'sd2);
    wait_drained();
    write_window(7'd6);
    send_item(ITEM_NEXT, 64'sd9);
    send_item(ITEM_NEXT, 64'sd1);
    send_item(ITEM_NEXT, 64'sd4);
    send_item(ITEM_NEXT, 64'sd8);
  endtask

  task automatic test_random_windows();
    logic [WLEN_BITS-1:0] widths [12] = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd2, 7'd5,
                                          7'd8, 7'd13, 7'd33, 7'd3, 7'd4, 7'd6};
    int unsigned weff;
    int unsigned budget;
    int unsigned len;
    hash_style_t style;
    item_kind_t first;
    foreach (widths[p]) begin
      wait_drained();
      write_window(widths[p]);
      weff = effective_width(widths[p]);
      budget = (weff >= 32) ? 70 : 18;
      first = ($urandom_range(0, 2) == 0) ? ITEM_NEXT : ITEM_START;
      while (budget != 0) begin
        len = (weff >= 32) ? budget : $urandom_range(1, 2 * weff + 3);
        if (len > budget) len = budget;
        style = hash_style_t'($urandom_range(0, 3));
        for (int unsigned k = 0; k < len; k++)
          send_item((k == 0) ? first : stray_kind(), pick_hash(style));
        budget -= len;
        first = ITEM_START;
      end
    end
  endtask

  // sink holds off while a descending run keeps producing results
  task automatic test_backpressure();
    wait_drained();
    write_window(7'd8);
    hold_request = 1'b1;
    src_gaps = 1'b0;
    for (int k = 0; k < 24; k++)
      send_item((k == 0) ? ITEM_START : ITEM_NEXT, 64'sd1000 - longint'(k));
    src_gaps = 1'b1;
  endtask

  task automatic test_full_rate();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    for (int k = 0; k < 40; k++)
      send_item((k == 0) ? ITEM_START : ITEM_NEXT,
                pick_hash(hash_style_t'($urandom_range(0, 3))));
  endtask

  always @(posedge clk) begin
    logic [POS_OUT_BITS-1:0] want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_positions.size() == 0) begin
        flag_mismatch("unexpected result", '0, out_if.selected_position);
      end else begin
        want = pending_positions.pop_front();
        if (out_if.selected_position !== want)
          flag_mismatch("selected_position", want, out_if.selected_position);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.hash_value <= '0;
    in_if.start_of_list <= 1'b0;
    clear_ring();
    wlen_q = WLEN_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_window();
    test_hash_extremes();
    test_window_change_midstream();
    test_random_windows();
    test_backpressure();
    test_full_rate();
    wait_drained();

    if (mismatch_count == 0 && pending_positions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
